// ===== rtl/core/mbd_pkg.sv =====
`default_nettype none

package mbd_pkg;

  // sizes
  localparam int unsigned MaxWidthDef = 4096;
  localparam int ChW        = 16;
  localparam int PixW       = 64;
  localparam int ModeW      = 2;
  localparam int SrcWidthW  = 13;
  localparam int SrcHeightW = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int DivSteps   = 34;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FILTER_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_HEIGHT = 2'd2;

  // filter modes, the unused code acts as plain
  localparam logic [ModeW-1:0] MODE_PLAIN = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALPHA = 2'd1;
  localparam logic [ModeW-1:0] MODE_UNIT  = 2'd2;

  // channel slots inside a packed pixel
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef logic [PixW-1:0] pixel_t;

  typedef struct packed {
    pixel_t [3:0] tap;
    logic         last;
  } tapset_t;

  typedef struct packed {
    logic signed [ChW-1:0] red;
    logic signed [ChW-1:0] green;
    logic signed [ChW-1:0] blue;
    logic signed [ChW-1:0] alpha;
    logic                  last;
  } result_t;

  // what the front does with one source pixel
  typedef enum logic [2:0] {
    K_NONE,
    K_HELD,
    K_ROW_EMIT,
    K_ONE_EMIT,
    K_COL_EMIT,
    K_PAIR_EVEN,
    K_PAIR_ODD
  } tap_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_MUL,
    BK_ACC,
    BK_DSET,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_e;

  function automatic logic signed [ChW-1:0] chan(pixel_t px, logic [1:0] idx);
    return px[idx*ChW +: ChW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mbd_if.sv =====
`default_nettype none

interface mbd_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] red_in;
  logic signed [15:0] green_in;
  logic signed [15:0] blue_in;
  logic signed [15:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mbd_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] red_out;
  logic signed [15:0] green_out;
  logic signed [15:0] blue_out;
  logic signed [15:0] alpha_out;
  logic               frame_last;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  output ready);
endinterface

interface mbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mbd_ram.sv =====
`default_nettype none

module mbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbd_fifo.sv =====
`default_nettype none

module mbd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  mbd_pkg::tapset_t      data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output mbd_pkg::tapset_t      data_o
);
  import mbd_pkg::*;

  tapset_t    entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbd_front.sv =====
`default_nettype none

module mbd_front #(
  parameter int unsigned MAX_WIDTH = mbd_pkg::MaxWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mbd_pkg::SrcWidthW-1:0]  src_width_i,
  input  wire logic [mbd_pkg::SrcHeightW-1:0] src_height_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  mbd_pkg::pixel_t                    pixel_i,
  output logic                               q_push_o,
  output mbd_pkg::tapset_t                   q_data_o,
  input  wire logic                          q_ready_i
);
  import mbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (LW > SrcWidthW) ? LW : SrcWidthW;
  localparam int HW = SrcHeightW;

  logic [CW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [WW-1:0] w_eff, sw_x, c_inc;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] c_cur;
  logic [HW-1:0] r_cur;
  logic [HW:0]   r_inc;
  logic          w_one, h_one, row_used, last_col, last_row;
  logic          accept, store_we;
  tap_kind_e     kind;

  logic          s1_valid_q;
  tap_kind_e     s1_kind_q;
  pixel_t        s1_pix_q;
  logic          s1_last_q;
  logic          s1_emit, s1_go;
  pixel_t        held_q, prev_q, rd_pix;

  // effective size, zero acts as one, width capped at the store depth
  always_comb begin
    sw_x = WW'(src_width_i);
    if (sw_x == '0) begin
      w_eff = WW'(1);
    end else if (sw_x > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = sw_x;
    end
    h_eff = (src_height_i == '0) ? HW'(1) : src_height_i;
  end

  assign c_cur    = (WW'(col_q) >= w_eff) ? '0 : col_q;
  assign r_cur    = (row_q >= h_eff) ? '0 : row_q;
  assign w_one    = (w_eff == WW'(1));
  assign h_one    = (h_eff == HW'(1));
  assign row_used = (r_cur < {h_eff[HW-1:1], 1'b0});
  assign last_col = w_one || (WW'(c_cur >> 1) == ((w_eff >> 1) - WW'(1)));
  assign last_row = h_one || ((r_cur >> 1) == ((h_eff >> 1) - HW'(1)));

  always_comb begin
    kind = K_NONE;
    if (h_one) begin
      if (w_one) begin
        kind = K_ONE_EMIT;
      end else if (!c_cur[0]) begin
        kind = K_HELD;
      end else begin
        kind = K_ROW_EMIT;
      end
    end else if (row_used && r_cur[0]) begin
      if (w_one) begin
        kind = K_COL_EMIT;
      end else if (!c_cur[0]) begin
        kind = K_PAIR_EVEN;
      end else begin
        kind = K_PAIR_ODD;
      end
    end
  end

  assign accept   = in_valid_i && in_ready_o;
  assign store_we = accept && !h_one && row_used && !r_cur[0];

  // raster counters
  always_comb begin
    c_inc = WW'(c_cur) + WW'(1);
    r_inc = {1'b0, r_cur} + (HW+1)'(1);
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (c_inc >= w_eff) begin
        col_d = '0;
        row_d = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[HW-1:0];
      end else begin
        col_d = c_inc[CW-1:0];
        row_d = r_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  mbd_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (c_cur),
    .wdata_i (pixel_i),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (rd_pix)
  );

  // second stage waits for the line store read
  assign s1_emit = (s1_kind_q == K_ROW_EMIT) || (s1_kind_q == K_ONE_EMIT) ||
                   (s1_kind_q == K_COL_EMIT) || (s1_kind_q == K_PAIR_ODD);
  assign s1_go      = s1_valid_q && (!s1_emit || q_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign q_push_o   = s1_valid_q && s1_emit && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= K_NONE;
      held_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_kind_q  <= kind;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go && ((s1_kind_q == K_HELD) || (s1_kind_q == K_PAIR_EVEN))) begin
        held_q <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_last_q <= last_col && last_row;
    end
    if (s1_go && (s1_kind_q == K_PAIR_EVEN)) begin
      prev_q <= rd_pix;
    end
  end

  always_comb begin
    q_data_o.last = s1_last_q;
    q_data_o.tap  = {s1_pix_q, s1_pix_q, s1_pix_q, s1_pix_q};
    case (s1_kind_q)
      K_ROW_EMIT: q_data_o.tap = {s1_pix_q, held_q, s1_pix_q, held_q};
      K_COL_EMIT: q_data_o.tap = {s1_pix_q, s1_pix_q, rd_pix, rd_pix};
      K_PAIR_ODD: q_data_o.tap = {s1_pix_q, held_q, rd_pix, prev_q};
      default:    q_data_o.tap = {s1_pix_q, s1_pix_q, s1_pix_q, s1_pix_q};
    endcase
  end

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_emit && !q_ready_i) |-> !in_ready_o)
    else $error("input taken while a tap set is stalled");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel lost before second stage");

  a_held_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_go |=> $stable(held_q))
    else $error("held pixel changed without stage advance");

endmodule

`default_nettype wire

// ===== rtl/core/mbd_back.sv =====
`default_nettype none

module mbd_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [mbd_pkg::ModeW-1:0] mode_i,
  input  wire logic                     q_valid_i,
  output logic                          q_pop_o,
  input  mbd_pkg::tapset_t              q_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output mbd_pkg::result_t              out_data_o
);
  import mbd_pkg::*;

  back_state_e state_q, state_d;

  pixel_t [3:0]          tap_q;
  logic                  last_q;
  logic signed [ChW-1:0] res_q [3];
  logic signed [ChW-1:0] alpha_q;
  logic signed [17:0]    asum_q;
  logic                  norm_q;
  logic [3:0]            idx_q;
  logic signed [31:0]    prod_q;
  logic signed [34:0]    acc_q [3];
  logic [31:0]           sq_q;
  logic [DivSteps-1:0]   dvd_q;
  logic [16:0]           dvs_q, rem_q, len_q;
  logic                  neg_q;
  logic [5:0]            cnt_q;
  logic [31:0]           n_q, root_q, bit_q;
  logic                  out_valid_q;
  result_t               out_q;

  logic signed [17:0]    csum [3];
  logic signed [17:0]    asum;
  logic signed [ChW-1:0] avg [3];
  logic signed [ChW-1:0] mul_a, mul_b;
  logic                  acc_last, out_free;
  logic signed [34:0]    num, mag;
  logic [17:0]           rem_sh;
  logic                  div_ge;
  logic [16:0]           rem_nx;
  logic [DivSteps-1:0]   dvd_nx;
  logic signed [ChW-1:0] q_sat;
  logic [31:0]           sq_sum, rt_sum, root_nx;
  logic                  rt_ge;

  // box sums and plain averages, truncated toward zero
  always_comb begin
    asum = '0;
    for (int i = 0; i < 4; i++) begin
      asum = asum + 18'(chan(tap_q[i], CH_ALPHA));
    end
    for (int c = 0; c < 3; c++) begin
      csum[c] = '0;
      for (int i = 0; i < 4; i++) begin
        csum[c] = csum[c] + 18'(chan(tap_q[i], 2'(c)));
      end
      avg[c] = 16'((csum[c] + (csum[c][17] ? 18'sd3 : 18'sd0)) >>> 2);
    end
  end

  // shared multiplier operands
  always_comb begin
    if (norm_q) begin
      mul_a = res_q[idx_q[1:0]];
      mul_b = res_q[idx_q[1:0]];
    end else begin
      mul_a = chan(tap_q[idx_q[1:0]], idx_q[3:2]);
      mul_b = chan(tap_q[idx_q[1:0]], CH_ALPHA);
    end
  end

  assign acc_last = norm_q ? (idx_q == 4'd2) : (idx_q == 4'd11);
  assign sq_sum   = sq_q + 32'(prod_q);

  // divider operand setup
  always_comb begin
    if (norm_q) begin
      num = {{5{res_q[idx_q[1:0]][15]}}, res_q[idx_q[1:0]], 14'b0};
    end else begin
      num = acc_q[idx_q[1:0]];
    end
    mag = num[34] ? -num : num;
  end

  // one restoring divide step
  always_comb begin
    rem_sh = {rem_q, dvd_q[DivSteps-1]};
    div_ge = (rem_sh >= {1'b0, dvs_q});
    rem_nx = div_ge ? 17'(rem_sh - {1'b0, dvs_q}) : rem_sh[16:0];
    dvd_nx = {dvd_q[DivSteps-2:0], div_ge};
    if (neg_q) begin
      q_sat = (dvd_nx > DivSteps'(32768)) ? 16'sh8000 : 16'(-dvd_nx[15:0]);
    end else begin
      q_sat = (dvd_nx > DivSteps'(32767)) ? 16'sh7fff : 16'(dvd_nx[15:0]);
    end
  end

  // one square root step, two bits of the radicand
  always_comb begin
    rt_sum  = root_q + bit_q;
    rt_ge   = (n_q >= rt_sum);
    root_nx = rt_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BK_SUM;
        end
      end
      BK_SUM: begin
        if ((mode_i == MODE_ALPHA) && (asum > 18'sd0)) begin
          state_d = BK_MUL;
        end else if (mode_i == MODE_UNIT) begin
          state_d = BK_MUL;
        end else begin
          state_d = BK_OUT;
        end
      end
      BK_MUL: state_d = BK_ACC;
      BK_ACC: begin
        if (!acc_last) begin
          state_d = BK_MUL;
        end else if (norm_q) begin
          state_d = BK_SQRT;
        end else begin
          state_d = BK_DSET;
        end
      end
      BK_DSET: state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = (idx_q == 4'd2) ? BK_OUT : BK_DSET;
        end
      end
      BK_SQRT: begin
        if (bit_q[0]) begin
          state_d = (root_nx == '0) ? BK_OUT : BK_DSET;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == BK_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          tap_q  <= q_data_i.tap;
          last_q <= q_data_i.last;
        end
      end
      BK_SUM: begin
        for (int c = 0; c < 3; c++) begin
          res_q[c] <= avg[c];
          acc_q[c] <= '0;
        end
        alpha_q    <= 16'((asum + (asum[17] ? 18'sd3 : 18'sd0)) >>> 2);
        asum_q     <= asum;
        norm_q     <= !((mode_i == MODE_ALPHA) && (asum > 18'sd0));
        idx_q      <= '0;
        sq_q       <= '0;
      end
      BK_MUL: prod_q <= mul_a * mul_b;
      BK_ACC: begin
        if (norm_q) begin
          sq_q <= sq_sum;
        end else begin
          acc_q[idx_q[3:2]] <= acc_q[idx_q[3:2]] + 35'(prod_q);
        end
        if (acc_last) begin
          idx_q <= '0;
          if (norm_q) begin
            n_q    <= sq_sum;
            root_q <= '0;
            bit_q  <= 32'h4000_0000;
          end
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      BK_DSET: begin
        dvd_q <= mag[DivSteps-1:0];
        dvs_q <= norm_q ? len_q : asum_q[16:0];
        neg_q <= num[34];
        rem_q <= '0;
        cnt_q <= '0;
      end
      BK_DIV: begin
        dvd_q <= dvd_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          res_q[idx_q[1:0]] <= q_sat;
          idx_q <= idx_q + 4'd1;
        end
      end
      BK_SQRT: begin
        if (rt_ge) begin
          n_q <= n_q - rt_sum;
        end
        root_q <= root_nx;
        bit_q  <= bit_q >> 2;
        len_q  <= root_nx[16:0];
      end
      BK_OUT: begin
        if (out_free) begin
          out_q.red   <= res_q[0];
          out_q.green <= res_q[1];
          out_q.blue  <= res_q[2];
          out_q.alpha <= alpha_q;
          out_q.last  <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/mip_box_downsample_2x2.sv =====
// 2x2 box-filter mip downsampler, one half-size level from a raster stream
//
// channels: pix_i takes one source rgba word (q2.14 each) per handshake in
//   raster order; res_o gives one averaged word per 2x2 block, frame_last
//   high on the final word of the level; cfg_i writes filter_mode (index 0),
//   source_width (1) and source_height (2), taken every cycle
// throughput: the front takes one pixel per cycle while its two-entry tap
//   queue has room; the back takes a tap set only when idle, then passes
//   sum and output states in plain mode; alpha-weighted mode adds 12 serial
//   multiplies and three 34-step divides, unit-vector mode 3 multiplies, a
//   16-step square root and, for a nonzero length, three 34-step divides
// path: the front's second stage and the queue are registered; the back
//   loads the output register as it leaves its output state
// reset: counters cleared, mode plain, width and height one; line store
//   contents are undefined and get no clearing pass, a row is always
//   written before its stored pixels are used
// stall: a held output word does not stop the back from working on the
//   next block; pix_i ready drops when a tap set waits on a full queue
`default_nettype none

module mip_box_downsample_2x2 #(
  parameter int unsigned MAX_WIDTH = mbd_pkg::MaxWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbd_pix_if.sink   pix_i,
  mbd_res_if.source res_o,
  mbd_cfg_if.sink   cfg_i
);
  import mbd_pkg::*;

  // configuration registers
  logic [ModeW-1:0]      mode_q;
  logic [SrcWidthW-1:0]  width_q;
  logic [SrcHeightW-1:0] height_q;

  // front to queue to back
  pixel_t  pix_word;
  tapset_t fq_data, qb_data;
  logic    fq_push, fq_ready, qb_valid, qb_pop;
  result_t res_word;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PLAIN;
      width_q  <= SrcWidthW'(1);
      height_q <= SrcHeightW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FILTER_MODE:   mode_q   <= cfg_i.data[ModeW-1:0];
        CFG_SOURCE_WIDTH:  width_q  <= cfg_i.data[SrcWidthW-1:0];
        CFG_SOURCE_HEIGHT: height_q <= cfg_i.data[SrcHeightW-1:0];
        default: ;
      endcase
    end
  end

  // pack channels red in the low word up to alpha on top
  assign pix_word = {pix_i.alpha_in, pix_i.blue_in, pix_i.green_in, pix_i.red_in};

  // front: counts raster position, keeps the even row, forms tap sets
  mbd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_width_i  (width_q),
    .src_height_i (height_q),
    .in_valid_i   (pix_i.valid),
    .in_ready_o   (pix_i.ready),
    .pixel_i      (pix_word),
    .q_push_o     (fq_push),
    .q_data_o     (fq_data),
    .q_ready_i    (fq_ready)
  );

  // short queue so the front keeps streaming while the back iterates
  mbd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_data),
    .ready_o (fq_ready),
    .valid_o (qb_valid),
    .pop_i   (qb_pop),
    .data_o  (qb_data)
  );

  // back: averaging, weighting and renormalization
  mbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .q_valid_i   (qb_valid),
    .q_pop_o     (qb_pop),
    .q_data_i    (qb_data),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_word)
  );

  assign res_o.red_out    = res_word.red;
  assign res_o.green_out  = res_word.green;
  assign res_o.blue_out   = res_word.blue;
  assign res_o.alpha_out  = res_word.alpha;
  assign res_o.frame_last = res_word.last;

endmodule

`default_nettype wire
